>>> src/ipcs_pkg.sv
// Shared types for the in-place counting sort unit: controller commands and datapath status.
`default_nettype none
package ipcs_pkg;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic in_rdy;    // input channel may take a transaction
        logic clr_wr;    // clearing pass: zero one count entry
        logic ct_rd;     // count pass: read count of stored key
        logic ct_inc;    // count pass: write incremented count
        logic idx_next;  // step key-store index
        logic idx_clr;   // rewind key-store index
        logic val_init;  // start value scan at zero
        logic val_next;  // step value scan
        logic ev_latch;  // latch count of current value, zero the entry
        logic emit;      // load one result into the output register
        logic finish;    // clear set state
    } t_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic in_valid;
        logic in_last;
        logic clr_last;  // clearing pass on its final entry
        logic idx_last;  // index on the final stored key
        logic rem_zero;  // no keys left for current value
        logic val_last;  // scan on the key limit
        logic out_free;  // output register can take a result
        logic run_last;  // next result ends the run
    } t_sts;

endpackage
`default_nettype wire

>>> src/ipcs_in_if.sv
// Input channel: one key per transaction.
`default_nettype none
interface ipcs_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] key;
    logic       last;

    modport source (output valid, output key, output last, input ready);
    modport sink   (input valid, input key, input last, output ready);
endinterface
`default_nettype wire

>>> src/ipcs_out_if.sv
// Output channel: one sorted key per transaction.
`default_nettype none
interface ipcs_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] sorted_key;
    logic       end_of_run;
    logic       trouble;

    modport source (output valid, output sorted_key, output end_of_run, output trouble,
                    input ready);
    modport sink   (input valid, input sorted_key, input end_of_run, input trouble,
                    output ready);
endinterface
`default_nettype wire

>>> src/in_place_counting_sort_unit.sv
// Top level of the in-place counting sort unit.
// Keys are taken one per cycle while loading; a transaction with last set closes the set,
// after which the unit takes no input until the sorted run has been handed out. For each
// stored key, sorting reads the key store, reads the count table entry of the key and
// writes that count back incremented; then a scan over key values from 0 up to the
// largest key of the set reads and latches each value's count, zeroing its entry, and
// emits that value's keys one per cycle while the output register is free. The count
// table is cleared as the run is emitted; after reset a clearing pass over all
// KEY_RANGE entries runs before the first key is taken. Keys above key_max are clamped
// and keys beyond MAX_ITEMS dropped; either raises trouble on every result of the set.
`default_nettype none
module in_place_counting_sort_unit
    import ipcs_pkg::*;
#(
    parameter int MAX_ITEMS = 64,
    parameter int KEY_RANGE = 256
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_wr_en,
    input  wire logic [7:0] i_cfg_wr_data,
    ipcs_in_if.sink         i_in,
    ipcs_out_if.source      o_out
);
    t_cmd cmd;
    t_sts sts;

    // Controller
    ipcs_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    // Datapath
    ipcs_dp #(.MAX_ITEMS(MAX_ITEMS), .KEY_RANGE(KEY_RANGE)) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_in          (i_in),
        .o_out         (o_out)
    );
endmodule
`default_nettype wire

>>> src/ipcs_ram.sv
// Generic RAM: one write port, one read port, registered read data.
`default_nettype none
module ipcs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

>>> src/ipcs_ctrl.sv
// Sort controller: sequences clearing, loading, counting and emission.
`default_nettype none
module ipcs_ctrl
    import ipcs_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd
);
    typedef enum logic [7:0] {
        S_CLR   = 8'b0000_0001,
        S_LOAD  = 8'b0000_0010,
        S_C_KS  = 8'b0000_0100,
        S_C_CT  = 8'b0000_1000,
        S_C_WR  = 8'b0001_0000,
        S_E_RD  = 8'b0010_0000,
        S_E_WT  = 8'b0100_0000,
        S_E_OUT = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_CLR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_sts.clr_last) n_state = S_LOAD;
            end
            S_LOAD: begin
                o_cmd.in_rdy = 1'b1;
                if (i_sts.in_valid && i_sts.in_last) n_state = S_C_KS;
            end
            S_C_KS: n_state = S_C_CT;
            S_C_CT: begin
                o_cmd.ct_rd = 1'b1;
                n_state     = S_C_WR;
            end
            S_C_WR: begin
                o_cmd.ct_inc = 1'b1;
                if (i_sts.idx_last) begin
                    o_cmd.idx_clr  = 1'b1;
                    o_cmd.val_init = 1'b1;
                    n_state        = S_E_RD;
                end else begin
                    o_cmd.idx_next = 1'b1;
                    n_state        = S_C_KS;
                end
            end
            S_E_RD: n_state = S_E_WT;
            S_E_WT: begin
                o_cmd.ev_latch = 1'b1;
                n_state        = S_E_OUT;
            end
            S_E_OUT: begin
                if (i_sts.rem_zero) begin
                    o_cmd.val_next = 1'b1;
                    n_state        = S_E_RD;
                end else if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_sts.run_last) begin
                        o_cmd.finish = 1'b1;
                        n_state      = S_LOAD;
                    end
                end
            end
            default: n_state = S_CLR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
        end else begin
            r_state <= n_state;
        end
    end

    // A result is only loaded into a free output register
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |-> i_sts.out_free)
        else $error("emit into occupied output register");

    // Counts sum to the run length, so the run ends before the scan runs dry
    a_scan_dry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_E_OUT && i_sts.rem_zero) |-> !i_sts.val_last)
        else $error("value scan reached limit without ending run");

    // A finished run returns to loading
    a_finish_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |=> r_state == S_LOAD)
        else $error("finish did not return to loading");
endmodule
`default_nettype wire

>>> src/ipcs_dp.sv
// Sort datapath: key store, count table, counters and output register.
`default_nettype none
module ipcs_dp
    import ipcs_pkg::*;
#(
    parameter int MAX_ITEMS = 64,
    parameter int KEY_RANGE = 256
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_wr_en,
    input  wire logic [7:0] i_cfg_wr_data,
    input  wire t_cmd       i_cmd,
    output t_sts            o_sts,
    ipcs_in_if.sink         i_in,
    ipcs_out_if.source      o_out
);
    localparam int FW = $clog2(MAX_ITEMS + 1);
    localparam int IW = $clog2(MAX_ITEMS);
    localparam int KW = $clog2(KEY_RANGE);
    localparam logic [7:0] RANGE_TOP = (KEY_RANGE - 1 > 255) ? 8'd255 : 8'(KEY_RANGE - 1);

    logic [7:0]    r_key_max;
    logic [FW-1:0] r_fill;
    logic [FW-1:0] r_idx;
    logic [FW-1:0] r_rem;
    logic [KW-1:0] r_clr;
    logic [7:0]    r_val;
    logic [7:0]    r_k;
    logic          r_trouble;
    logic          r_ovalid;
    logic [7:0]    r_okey;
    logic          r_oend;
    logic          r_otrb;

    logic [7:0]    lim;
    logic [7:0]    in_key_c;
    logic [7:0]    ks_rdata;
    logic [7:0]    ks_key_c;
    logic [FW-1:0] ct_rdata;
    logic          ld;
    logic          full;
    logic          ct_we;
    logic [KW-1:0] ct_waddr;
    logic [KW-1:0] ct_raddr;
    logic [FW-1:0] ct_wdata;

    // Key limit and clamping
    assign lim      = (r_key_max > RANGE_TOP) ? RANGE_TOP : r_key_max;
    assign in_key_c = (i_in.key > lim) ? lim : i_in.key;
    assign ks_key_c = (ks_rdata > lim) ? lim : ks_rdata;
    assign ld       = i_cmd.in_rdy && i_in.valid;
    assign full     = (r_fill == FW'(MAX_ITEMS));

    assign i_in.ready = i_cmd.in_rdy;

    // Key store
    ipcs_ram #(.WIDTH(8), .DEPTH(MAX_ITEMS)) u_key_store (
        .i_clk   (i_clk),
        .i_we    (ld && !full),
        .i_waddr (r_fill[IW-1:0]),
        .i_wdata (in_key_c),
        .i_raddr (r_idx[IW-1:0]),
        .o_rdata (ks_rdata)
    );

    // Count table port selection
    assign ct_raddr = i_cmd.ct_rd ? KW'(ks_key_c) : KW'(r_val);
    assign ct_we    = i_cmd.clr_wr || i_cmd.ct_inc || i_cmd.ev_latch;
    assign ct_waddr = i_cmd.clr_wr ? r_clr : (i_cmd.ct_inc ? KW'(r_k) : KW'(r_val));
    assign ct_wdata = i_cmd.ct_inc ? ct_rdata + FW'(1) : '0;

    ipcs_ram #(.WIDTH(FW), .DEPTH(KEY_RANGE)) u_count (
        .i_clk   (i_clk),
        .i_we    (ct_we),
        .i_waddr (ct_waddr),
        .i_wdata (ct_wdata),
        .i_raddr (ct_raddr),
        .o_rdata (ct_rdata)
    );

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_max <= 8'd255;
            r_fill    <= '0;
            r_idx     <= '0;
            r_clr     <= '0;
            r_trouble <= 1'b0;
            r_ovalid  <= 1'b0;
        end else begin
            if (i_cfg_wr_en) r_key_max <= i_cfg_wr_data;
            if (i_cmd.clr_wr) r_clr <= r_clr + KW'(1);
            if (ld) begin
                if (!full) r_fill <= r_fill + FW'(1);
                if (full || i_in.key > lim) r_trouble <= 1'b1;
            end
            if (i_cmd.idx_next || i_cmd.emit) r_idx <= r_idx + FW'(1);
            if (i_cmd.idx_clr) r_idx <= '0;
            if (i_cmd.finish) begin
                r_fill    <= '0;
                r_idx     <= '0;
                r_trouble <= 1'b0;
            end
            if (o_out.ready) r_ovalid <= 1'b0;
            if (i_cmd.emit) r_ovalid <= 1'b1;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.ct_rd) r_k <= ks_key_c;
        if (i_cmd.val_init) r_val <= '0;
        if (i_cmd.val_next) r_val <= r_val + 8'd1;
        if (i_cmd.ev_latch) r_rem <= ct_rdata;
        if (i_cmd.emit) begin
            r_rem  <= r_rem - FW'(1);
            r_okey <= r_val;
            r_oend <= o_sts.run_last;
            r_otrb <= r_trouble;
        end
    end

    assign o_out.valid      = r_ovalid;
    assign o_out.sorted_key = r_okey;
    assign o_out.end_of_run = r_oend;
    assign o_out.trouble    = r_otrb;

    // Status
    assign o_sts.in_valid = i_in.valid;
    assign o_sts.in_last  = i_in.last;
    assign o_sts.clr_last = (r_clr == KW'(KEY_RANGE - 1));
    assign o_sts.idx_last = ((r_idx + FW'(1)) == r_fill);
    assign o_sts.rem_zero = (r_rem == '0);
    assign o_sts.val_last = (r_val == lim);
    assign o_sts.out_free = !r_ovalid || o_out.ready;
    assign o_sts.run_last = ((r_idx + FW'(1)) == r_fill);

    // Fill level stays within the store
    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FW'(MAX_ITEMS))
        else $error("fill level beyond capacity");
endmodule
`default_nettype wire
